// File: hw/rtl/atan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atan_pkg: shared types and constants for the cordic atan2 core
// step angle table, fold offsets and the data word handed along the cell row
// ----------------------------------------------------------------------------
package atan_pkg;

  localparam int DATA_W      = 16;
  localparam int ACC_W       = 16;
  localparam int TABLE_LEN   = 12;
  localparam int ITER_DEFAULT = 8;
  localparam int ITER_MAX    = TABLE_LEN - 1;

  localparam logic signed [ACC_W-1:0] HALF_TURN    = 16'sd18000;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 16'sd9000;

  // atan(2^-i) in centidegrees
  localparam logic signed [ACC_W-1:0] STEP_ANGLE [TABLE_LEN] = '{
    16'sd4500, 16'sd2657, 16'sd1404, 16'sd713, 16'sd358, 16'sd179,
    16'sd90,   16'sd45,   16'sd22,   16'sd11,  16'sd6,   16'sd3
  };

  typedef struct packed {
    logic                     zero;
    logic [DATA_W-1:0]        ux;
    logic [DATA_W-1:0]        uy;
    logic signed [ACC_W-1:0]  acc;
  } cell_data_t;

endpackage
`default_nettype wire

// File: hw/rtl/atan_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atan_cell: one greedy cordic vectoring step
// rotates when uy exceeds ux shifted by the step index, registers the result
// ----------------------------------------------------------------------------
module atan_cell #(
  parameter int STEP = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire atan_pkg::cell_data_t  in_data,
  output logic                       out_valid,
  output atan_pkg::cell_data_t       out_data
);

  logic [atan_pkg::DATA_W-1:0] ux_sh;
  logic [atan_pkg::DATA_W-1:0] uy_sh;
  logic                        rotate;
  atan_pkg::cell_data_t        data_next;

  assign ux_sh  = in_data.ux >> STEP;
  assign uy_sh  = in_data.uy >> STEP;
  assign rotate = in_data.uy > ux_sh;

  always_comb begin
    data_next = in_data;
    if (rotate) begin
      data_next.ux  = in_data.ux + uy_sh;
      data_next.uy  = in_data.uy - ux_sh;
      data_next.acc = in_data.acc + atan_pkg::STEP_ANGLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/atan2_cordic_centidegrees_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atan2_cordic_centidegrees_core: four-quadrant arctangent in centidegrees
// quadrant fold, iterative normalization and a row of cordic cells
// ----------------------------------------------------------------------------
// Takes a signed 16-bit (y, x) pair and returns atan2 in hundredths of a
// degree, 0 for the zero vector. One item is in flight at a time. After the
// input transfer the vector is folded into the first quadrant, then doubled
// one bit per cycle until a component reaches 2^14, then walks through a
// row of min(ITER,11)+1 cordic cells, one per cycle. The result is
// registered after the last cell, and the next input is taken the cycle
// after the result transfer. The normalizing shift loop makes the time to
// the result depend on the input.
module atan2_cordic_centidegrees_core #(
  parameter int ITER = atan_pkg::ITER_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] y_value,
  input  wire logic signed [15:0] x_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      angle_centideg
);

  localparam int LAST  = (ITER > atan_pkg::ITER_MAX) ? atan_pkg::ITER_MAX : ITER;
  localparam int NCELL = LAST + 1;
  localparam logic signed [atan_pkg::ACC_W-1:0] FINAL_ADD =
    atan_pkg::STEP_ANGLE[LAST] / 16'sd2;
  localparam logic [atan_pkg::DATA_W-1:0] NORM_LIMIT = 16'h4000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NORM = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [atan_pkg::DATA_W-1:0]       ux;
  logic [atan_pkg::DATA_W-1:0]       uy;
  logic signed [atan_pkg::ACC_W-1:0] acc;
  logic                              zero;

  logic                              in_xfer;
  logic                              out_xfer;
  logic                              norm_done;
  logic                              launch;

  // quadrant fold
  logic [atan_pkg::DATA_W-1:0]       y_fold;
  logic [atan_pkg::DATA_W-1:0]       x_fold;
  logic [atan_pkg::DATA_W-1:0]       ux_fold;
  logic [atan_pkg::DATA_W-1:0]       uy_fold;
  logic signed [atan_pkg::ACC_W-1:0] acc_fold;

  logic                 chain_valid [NCELL+1];
  atan_pkg::cell_data_t chain_data  [NCELL+1];
  atan_pkg::cell_data_t last_data;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign norm_done = zero || (ux >= NORM_LIMIT) || (uy >= NORM_LIMIT);
  assign launch    = (state == ST_NORM) && norm_done;

  always_comb begin
    acc_fold = '0;
    y_fold   = y_value;
    x_fold   = x_value;
    if (y_value[15]) begin
      y_fold   = -y_value;
      x_fold   = -x_value;
      acc_fold = -atan_pkg::HALF_TURN;
    end
    if (x_fold[15]) begin
      ux_fold  = y_fold;
      uy_fold  = -x_fold;
      acc_fold = acc_fold + atan_pkg::QUARTER_TURN;
    end else begin
      ux_fold  = x_fold;
      uy_fold  = y_fold;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_NORM;
      ST_NORM: if (norm_done) state_next = ST_RUN;
      ST_RUN:  if (chain_valid[NCELL]) state_next = ST_DONE;
      ST_DONE: if (out_xfer) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ux   <= ux_fold;
      uy   <= uy_fold;
      acc  <= acc_fold;
      zero <= (y_value == '0) && (x_value == '0);
    end else if (state == ST_NORM && !norm_done) begin
      ux <= {ux[atan_pkg::DATA_W-2:0], 1'b0};
      uy <= {uy[atan_pkg::DATA_W-2:0], 1'b0};
    end
  end

  assign chain_valid[0]     = launch;
  assign chain_data[0].zero = zero;
  assign chain_data[0].ux   = ux;
  assign chain_data[0].uy   = uy;
  assign chain_data[0].acc  = acc;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    atan_cell #(
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  assign last_data = chain_data[NCELL];

  always_ff @(posedge clk) begin
    if (state == ST_RUN && chain_valid[NCELL]) begin
      angle_centideg <= last_data.zero ? '0 : last_data.acc + FINAL_ADD;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/atan_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atan_checker: port-level checks for the cordic atan2 core
// single item in flight, result range, input and output hold under stall
// ----------------------------------------------------------------------------
module atan_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [15:0] y_value,
  input wire logic signed [15:0] x_value,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] angle_centideg
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_centideg))
    else $error("result changed while stalled");

  // stalled input holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(y_value) && $stable(x_value))
    else $error("input changed while stalled");

  // busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // no input taken while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // angle range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_centideg >= -16'sd18000) && (angle_centideg <= 16'sd19000))
    else $error("angle out of range");

endmodule

bind atan2_cordic_centidegrees_core atan_checker u_atan_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .y_value        (y_value),
  .x_value        (x_value),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .angle_centideg (angle_centideg)
);
`default_nettype wire

// File: tb/atan2_cordic_centidegrees_core_test.sv
// ----------------------------------------------------------------------------
// atan2_cordic_centidegrees_core_test: self-checking bench for the atan2 core
// a queue-fed driver sends (y, x) pairs with random gaps, a monitor checks
// each angle against a bit-exact cordic predictor under random output stalls
// ----------------------------------------------------------------------------
module atan2_cordic_centidegrees_core_test;

  localparam int ITER        = 8;
  localparam int LAST_ROT    = (ITER > 11) ? 11 : ITER;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int RANDOM_ITEMS = 1150;

  localparam int ROT_ANGLE [12] = '{4500, 2657, 1404, 713, 358, 179, 90, 45, 22, 11, 6, 3};
  localparam logic [15:0] CORNER_VALS [5] = '{16'h0000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff};

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vector_t;

  typedef struct {
    vector_t            v;
    logic signed [15:0] angle;
  } angle_rec_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] y_value = '0;
  logic signed [15:0] x_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] angle_centideg;

  vector_t    vector_queue [$];
  angle_rec_t angle_expect [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         in_quiet = 1'b0;
  bit         out_quiet = 1'b0;

  atan2_cordic_centidegrees_core #(.ITER(ITER)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .y_value        (y_value),
    .x_value        (x_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .angle_centideg (angle_centideg)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] cordic_angle(logic signed [15:0] y,
                                                      logic signed [15:0] x);
    int                 acc;
    logic signed [15:0] fy, fx;
    logic [15:0]        ux, uy, ux_old;
    acc = 0;
    if (x == 0 && y == 0) return '0;
    fy = y;
    fx = x;
    // lower half plane, -32768 stays negative after the wrap
    if (fy < 0) begin
      fy = -fy;
      fx = -fx;
      acc -= 18000;
    end
    if (fx < 0) begin
      ux = fy;
      uy = -fx;
      acc += 9000;
    end else begin
      ux = fx;
      uy = fy;
    end
    while (ux < 16'd16384 && uy < 16'd16384) begin
      ux = ux << 1;
      uy = uy << 1;
    end
    for (int i = 0; i <= LAST_ROT; i++) begin
      if (uy > (ux >> i)) begin
        ux_old = ux;
        ux = ux + (uy >> i);
        uy = uy - (ux_old >> i);
        acc += ROT_ANGLE[i];
      end
    end
    acc += ROT_ANGLE[LAST_ROT] / 2;
    return 16'(acc);
  endfunction

  task automatic add_vector(int y, int x);
    vector_t v;
    v.y = 16'(y);
    v.x = 16'(x);
    vector_queue.push_back(v);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    vector_t    nxt;
    angle_rec_t rec;
    int         gap;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      rec.v.y = y_value;
      rec.v.x = x_value;
      rec.angle = cordic_angle(y_value, x_value);
      angle_expect.push_back(rec);
      if ($urandom_range(0, 39) == 0) in_quiet <= !in_quiet;
      gap = in_quiet ? 0 : $urandom_range(0, 11);
      if (gap == 0 && vector_queue.size() != 0) begin
        nxt = vector_queue.pop_front();
        y_value <= nxt.y;
        x_value <= nxt.x;
      end else begin
        in_valid <= 1'b0;
        gap_left <= gap;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (vector_queue.size() != 0) begin
        nxt = vector_queue.pop_front();
        y_value <= nxt.y;
        x_value <= nxt.x;
        in_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_proc
    angle_rec_t rec;
    int         d;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (angle_expect.size() == 0) begin
        $display("%0t: angle %0d with no transfer pending", $time, angle_centideg);
        mismatches++;
      end else begin
        rec = angle_expect.pop_front();
        if (angle_centideg !== rec.angle) begin
          $display("%0t: y=%0d x=%0d expected %0d, actual %0d",
                   $time, rec.v.y, rec.v.x, rec.angle, angle_centideg);
          mismatches++;
        end
      end
      if ($urandom_range(0, 39) == 0) out_quiet <= !out_quiet;
      d = out_quiet ? 0 : $urandom_range(0, 11);
      stall_left <= d;
      out_stall <= (d != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    int a, b, kind;
    // directed corners
    add_vector(0, 0);
    add_vector(0, 1);
    add_vector(1, 0);
    add_vector(0, -1);
    add_vector(-1, 0);
    add_vector(32767, 32767);
    add_vector(-32768, -32768);
    add_vector(-32768, 0);
    add_vector(0, -32768);
    add_vector(-32768, 32767);
    add_vector(32767, -32768);
    add_vector(1, 1);
    add_vector(-1, -1);
    add_vector(1, -1);
    add_vector(-1, 1);
    add_vector(32767, 0);
    add_vector(0, 32767);
    add_vector(-32768, 1);
    add_vector(1, -32768);
    add_vector(16384, 0);
    add_vector(8191, 1);
    add_vector(100, -200);
    add_vector(-3, 5);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      kind = $urandom_range(0, 9);
      case (kind) inside
        [0:3]: begin
          a = $signed(16'($urandom()));
          b = $signed(16'($urandom()));
        end
        [4:5]: begin
          a = int'($urandom_range(0, 127)) - 64;
          b = int'($urandom_range(0, 127)) - 64;
        end
        6: begin
          a = $signed(16'($urandom()));
          b = $signed(16'($urandom()));
          a = a >>> $urandom_range(0, 14);
          b = b >>> $urandom_range(0, 14);
        end
        7: begin
          a = $signed(CORNER_VALS[$urandom_range(0, 4)]);
          b = $signed(16'($urandom()));
          if ($urandom_range(0, 1) == 1) begin
            kind = a;
            a = b;
            b = kind;
          end
        end
        8: begin
          a = $signed(CORNER_VALS[$urandom_range(0, 4)]);
          b = $signed(CORNER_VALS[$urandom_range(0, 4)]);
        end
        default: begin
          // near the diagonals
          a = $signed(16'($urandom()));
          b = ($urandom_range(0, 1) == 1) ? a : -a;
          b = b + int'($urandom_range(0, 4)) - 2;
        end
      endcase
      add_vector(a, b);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (vector_queue.size() != 0 || in_valid || angle_expect.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && angle_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/atan_pkg.sv
hw/rtl/atan_cell.sv
hw/rtl/atan2_cordic_centidegrees_core.sv
hw/rtl/atan_checker.sv
tb/atan2_cordic_centidegrees_core_test.sv
